/* hw/rtl/prdc_pkg.sv */
// shared types, constants and helpers for the press ram dwell controller
`default_nettype none

package prdc_pkg;

    // widths of the configuration registers
    localparam int THRESH_W = 16;
    localparam int PULSE_W  = 16;
    localparam int STEP_W   = 20;
    localparam int CFG_W    = 20;
    localparam int IDX_W    = 2;

    // counter widths
    localparam int BOUNCE_CNT_W = 16;
    localparam int DWELL_W      = 12;
    localparam int DWELL_WIDE_W = 16;

    // default dip switch width
    localparam int DIP_WIDTH_DEFAULT = 8;

    // dwell steps per dip unit and the dwell ceiling
    localparam int DWELL_SCALE = 10;
    localparam int DWELL_MAX   = 4095;

    // register reset values
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd50;
    localparam logic [PULSE_W-1:0]  PULSE_RESET  = 16'd100;
    localparam logic [STEP_W-1:0]   STEP_RESET   = 20'd100;

    // output tdata width: 18 payload bits padded to whole bytes
    localparam int OUT_W = 24;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_BOUNCE_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] CFG_PULSE_TICKS      = 2'd1;
    localparam logic [IDX_W-1:0] CFG_STEP_TICKS       = 2'd2;

    // phase codes as seen on the result stream
    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_RETRACT = 2'd1;
    localparam logic [1:0] PHASE_EXTEND  = 2'd2;
    localparam logic [1:0] PHASE_DWELL   = 2'd3;

    // sequencer state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_RETRACT = 4'b0010,
        ST_EXTEND  = 4'b0100,
        ST_DWELL   = 4'b1000
    } phase_t;

    // debounced switch levels after the current sample
    typedef struct packed {
        logic up;
        logic down;
    } levels_t;

    // sequencer view of the current tick
    typedef struct packed {
        logic               extend;
        logic               retract;
        logic [1:0]         phase;
        logic [DWELL_W-1:0] dwell_left;
    } seq_out_t;

    // map the one-hot state to its stream code
    function automatic logic [1:0] phase_code(input phase_t st);
        logic [1:0] code;
        case (st)
            ST_IDLE:    code = PHASE_IDLE;
            ST_RETRACT: code = PHASE_RETRACT;
            ST_EXTEND:  code = PHASE_EXTEND;
            ST_DWELL:   code = PHASE_DWELL;
            default:    code = PHASE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/prdc_debounce.sv */
// saturating accumulator debouncer for one switch
`default_nettype none

module prdc_debounce
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire logic                          sample,
    input  wire logic [prdc_pkg::THRESH_W-1:0] threshold,
    output logic                               level_next
);

    logic                                last_reg;
    logic [prdc_pkg::BOUNCE_CNT_W-1:0]   count_reg;
    logic [prdc_pkg::BOUNCE_CNT_W-1:0]   count_next;
    logic [prdc_pkg::BOUNCE_CNT_W-1:0]   count_step;
    logic                                level_reg;

    // count up on a repeat, down on a change, both saturating
    always_comb
    begin
        if (sample == last_reg)
        begin
            count_step = (&count_reg) ? count_reg : count_reg + 1'b1;
        end
        else
        begin
            count_step = (count_reg == '0) ? count_reg : count_reg - 1'b1;
        end
        count_next = count_step;
        level_next = level_reg;
        if (count_step > threshold)
        begin
            level_next = sample;
            count_next = '0;
        end
    end

    // state update on each accepted sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= 1'b0;
            count_reg <= '0;
            level_reg <= 1'b0;
        end
        else if (advance)
        begin
            last_reg  <= sample;
            count_reg <= count_next;
            level_reg <= level_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/prdc_sequencer.sv */
// retract, extend and dwell sequencer with pulse and step timers
`default_nettype none

module prdc_sequencer
#(
    parameter int DIP_WIDTH = prdc_pkg::DIP_WIDTH_DEFAULT
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          advance,
    input  wire prdc_pkg::levels_t             levels,
    input  wire logic [DIP_WIDTH-1:0]          dip,
    input  wire logic [prdc_pkg::PULSE_W-1:0]  pulse_ticks,
    input  wire logic [prdc_pkg::STEP_W-1:0]   step_ticks,
    output prdc_pkg::seq_out_t                 seq_out
);

    prdc_pkg::phase_t                   phase_reg;
    prdc_pkg::phase_t                   phase_next;
    logic [prdc_pkg::PULSE_W-1:0]       pulse_reg;
    logic [prdc_pkg::PULSE_W-1:0]       pulse_next;
    logic [prdc_pkg::PULSE_W-1:0]       pulse_inc;
    logic                               pulse_done;
    logic [prdc_pkg::DWELL_W-1:0]       dwell_reg;
    logic [prdc_pkg::DWELL_W-1:0]       dwell_next;
    logic [prdc_pkg::DWELL_W-1:0]       dwell_dec;
    logic [prdc_pkg::DWELL_W-1:0]       dwell_load;
    logic [prdc_pkg::DWELL_WIDE_W-1:0]  dwell_wide;
    logic [prdc_pkg::STEP_W-1:0]        step_reg;
    logic [prdc_pkg::STEP_W-1:0]        step_next;
    logic [prdc_pkg::STEP_W-1:0]        step_inc;
    logic                               step_done;

    // timer increments; a zero length acts as one tick
    assign pulse_inc  = pulse_reg + 1'b1;
    assign pulse_done = (pulse_inc >= pulse_ticks) || (pulse_inc == '0);
    assign step_inc   = step_reg + 1'b1;
    assign step_done  = (step_inc >= step_ticks) || (step_inc == '0);
    assign dwell_dec  = (dwell_reg == '0) ? dwell_reg : dwell_reg - 1'b1;

    // dwell length from the dip setting, clipped to the counter range
    assign dwell_wide = prdc_pkg::DWELL_WIDE_W'(dip)
                      * prdc_pkg::DWELL_WIDE_W'(prdc_pkg::DWELL_SCALE);
    assign dwell_load = (dwell_wide > prdc_pkg::DWELL_WIDE_W'(prdc_pkg::DWELL_MAX))
                      ? prdc_pkg::DWELL_W'(prdc_pkg::DWELL_MAX)
                      : dwell_wide[prdc_pkg::DWELL_W-1:0];

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        pulse_next = pulse_reg;
        dwell_next = dwell_reg;
        step_next  = step_reg;
        case (phase_reg)
            prdc_pkg::ST_IDLE:
            begin
                if (levels.up)
                begin
                    phase_next = prdc_pkg::ST_RETRACT;
                    pulse_next = '0;
                end
                else if (levels.down)
                begin
                    dwell_next = dwell_load;
                    phase_next = prdc_pkg::ST_EXTEND;
                    pulse_next = '0;
                end
            end
            prdc_pkg::ST_RETRACT:
            begin
                pulse_next = pulse_done ? '0 : pulse_inc;
                if (pulse_done)
                begin
                    phase_next = prdc_pkg::ST_IDLE;
                end
            end
            prdc_pkg::ST_EXTEND:
            begin
                pulse_next = pulse_done ? '0 : pulse_inc;
                if (pulse_done)
                begin
                    step_next  = '0;
                    phase_next = (dwell_reg != '0) ? prdc_pkg::ST_DWELL
                                                   : prdc_pkg::ST_RETRACT;
                end
            end
            prdc_pkg::ST_DWELL:
            begin
                if (levels.up)
                begin
                    // abort the dwell
                    dwell_next = '0;
                    step_next  = '0;
                    phase_next = prdc_pkg::ST_RETRACT;
                    pulse_next = '0;
                end
                else
                begin
                    step_next = step_done ? '0 : step_inc;
                    if (step_done)
                    begin
                        dwell_next = dwell_dec;
                        if (dwell_dec == '0)
                        begin
                            phase_next = prdc_pkg::ST_RETRACT;
                            pulse_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = prdc_pkg::ST_RETRACT;
                pulse_next = '0;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= prdc_pkg::ST_RETRACT;
            pulse_reg <= '0;
            dwell_reg <= '0;
            step_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pulse_reg <= pulse_next;
            dwell_reg <= dwell_next;
            step_reg  <= step_next;
        end
    end

    // view of this tick, before its transition
    assign seq_out.extend     = (phase_reg == prdc_pkg::ST_EXTEND);
    assign seq_out.retract    = (phase_reg == prdc_pkg::ST_RETRACT);
    assign seq_out.phase      = prdc_pkg::phase_code(phase_reg);
    assign seq_out.dwell_left = dwell_reg;

endmodule

`default_nettype wire

/* hw/rtl/press_ram_dwell_controller_top.sv */
// top level of the press ram dwell controller
// Each input transfer is one sample tick: raw up and down switch samples
// and the dip dwell setting. Every tick yields one result transfer with the
// solenoid drives, the phase, the remaining dwell steps and the debounced
// switch levels. A tick is taken every clock unless a held result stalls: the
// debouncers and the sequencer update between the input handshake and the result
// register, so the block sustains one transfer per cycle while the output is not
// stalled, with the result shown in the cycle after its tick, and accepts a new
// tick while the held result is being taken. Configuration writes are always
// ready; write them only while no tick is in flight.
`default_nettype none

module press_ram_dwell_controller_top
#(
    parameter int DIP_WIDTH = prdc_pkg::DIP_WIDTH_DEFAULT,
    localparam int IN_W     = ((DIP_WIDTH + 2 + 7) / 8) * 8
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,

    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // up_raw, down_raw, dip_setting
    input  wire logic [IN_W-1:0]             s_tdata,

    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // extend_drive, retract_drive, phase, dwell_left, up_pressed, down_pressed
    output logic [prdc_pkg::OUT_W-1:0]       m_tdata,

    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [prdc_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [prdc_pkg::CFG_W-1:0]  cfg_data
);

    localparam int PAD_W = prdc_pkg::OUT_W - prdc_pkg::DWELL_W - 6;

    logic [prdc_pkg::THRESH_W-1:0]  thresh_reg;
    logic [prdc_pkg::PULSE_W-1:0]   pulse_ticks_reg;
    logic [prdc_pkg::STEP_W-1:0]    step_ticks_reg;
    logic                           advance;
    prdc_pkg::levels_t              levels;
    prdc_pkg::seq_out_t             seq_out;
    logic                           out_valid_reg;
    logic [prdc_pkg::OUT_W-1:0]     out_data_reg;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg      <= prdc_pkg::THRESH_RESET;
            pulse_ticks_reg <= prdc_pkg::PULSE_RESET;
            step_ticks_reg  <= prdc_pkg::STEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                prdc_pkg::CFG_BOUNCE_THRESHOLD:
                    thresh_reg <= cfg_data[prdc_pkg::THRESH_W-1:0];
                prdc_pkg::CFG_PULSE_TICKS:
                    pulse_ticks_reg <= cfg_data[prdc_pkg::PULSE_W-1:0];
                prdc_pkg::CFG_STEP_TICKS:
                    step_ticks_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // input transfer whenever the result slot frees up
    assign s_tready = !out_valid_reg || m_tready;
    assign advance  = s_tvalid && s_tready;

    // switch debouncers
    prdc_debounce u_up_debounce
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .sample     (s_tdata[0]),
        .threshold  (thresh_reg),
        .level_next (levels.up)
    );

    prdc_debounce u_down_debounce
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .sample     (s_tdata[1]),
        .threshold  (thresh_reg),
        .level_next (levels.down)
    );

    // phase sequencer
    prdc_sequencer
    #(
        .DIP_WIDTH (DIP_WIDTH)
    )
    u_sequencer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .levels      (levels),
        .dip         (s_tdata[DIP_WIDTH+1:2]),
        .pulse_ticks (pulse_ticks_reg),
        .step_ticks  (step_ticks_reg),
        .seq_out     (seq_out)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= {PAD_W'(0), levels.down, levels.up, seq_out.dwell_left,
                             seq_out.phase, seq_out.retract, seq_out.extend};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // an accepted tick always shows up as a result next cycle
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
    else $error("accepted tick produced no result");

    // a held result blocks new ticks
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
    else $error("input accepted while result stalled");

    // remaining dwell only shows during the extend pulse or the dwell
    a_dwell_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[15:4] != '0)) |->
        ((m_tdata[3:2] == prdc_pkg::PHASE_EXTEND) ||
         (m_tdata[3:2] == prdc_pkg::PHASE_DWELL)))
    else $error("dwell count outside extend or dwell phase");

endmodule

`default_nettype wire

/* tb/sv/tb_press_ram_dwell_controller_top.sv */
// self-checking testbench for the press ram dwell controller top level
`default_nettype none

module tb_press_ram_dwell_controller_top;
    timeunit 1ns;
    timeprecision 1ps;

    import prdc_pkg::*;

    localparam int DIP_WIDTH  = DIP_WIDTH_DEFAULT;
    localparam int IN_W       = ((DIP_WIDTH + 2 + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 400000;
    localparam logic [IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // one result transfer, extend_drive in the lowest bit
    typedef struct packed {
        logic               down_pressed;
        logic               up_pressed;
        logic [DWELL_W-1:0] dwell_left;
        logic [1:0]         phase;
        logic               retract_drive;
        logic               extend_drive;
    } press_result_t;

    localparam int RES_W = $bits(press_result_t);

    // debounce accumulator of one switch
    typedef struct {
        logic                    last;
        logic [BOUNCE_CNT_W-1:0] count;
        logic                    level;
    } switch_filter_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // up_raw, down_raw, dip_setting
    logic [IN_W-1:0]       s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // extend_drive, retract_drive, phase, dwell_left, up_pressed, down_pressed
    logic [OUT_W-1:0]      m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    // shadow registers and sequencer state of the predictor
    logic [THRESH_W-1:0]   bounce_thr = THRESH_RESET;
    logic [PULSE_W-1:0]    pulse_len = PULSE_RESET;
    logic [STEP_W-1:0]     step_len = STEP_RESET;
    switch_filter_t        up_filt = '{1'b0, '0, 1'b0};
    switch_filter_t        down_filt = '{1'b0, '0, 1'b0};
    logic [1:0]            seq_phase = PHASE_RETRACT;
    logic [PULSE_W-1:0]    pulse_cnt = '0;
    logic [DWELL_W-1:0]    dwell_cnt = '0;
    logic [STEP_W-1:0]     step_cnt = '0;

    press_result_t         expected_drive_q[$];
    int                    mismatches = 0;
    int                    ticks_sent = 0;
    int                    send_idle_pct = 10;
    int                    recv_idle_pct = 71;
    int                    hold_left = 0;
    int                    cycle_count = 0;

    press_ram_dwell_controller_top #(.DIP_WIDTH(DIP_WIDTH)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // one sample into a debounce accumulator
    function automatic switch_filter_t filter_sample(switch_filter_t f, logic sample);
        if (sample == f.last)
        begin
            if (f.count != '1)
                f.count = f.count + 1'b1;
        end
        else
        begin
            if (f.count != '0)
                f.count = f.count - 1'b1;
            f.last = sample;
        end
        if (f.count > bounce_thr)
        begin
            f.level = sample;
            f.count = '0;
        end
        return f;
    endfunction

    // advance the pulse timer, true when the pulse ends
    function automatic bit pulse_finished();
        pulse_cnt = pulse_cnt + 1'b1;
        if (pulse_cnt >= pulse_len || pulse_cnt == '0)
        begin
            pulse_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // predict the result of one accepted tick and queue it
    task automatic advance_press_model(input logic up, input logic dn,
                                       input logic [DIP_WIDTH-1:0] dip);
        press_result_t r;
        logic [DWELL_WIDE_W-1:0] scaled;
        r.phase         = seq_phase;
        r.dwell_left    = dwell_cnt;
        r.extend_drive  = (seq_phase == PHASE_EXTEND);
        r.retract_drive = (seq_phase == PHASE_RETRACT);
        up_filt   = filter_sample(up_filt, up);
        down_filt = filter_sample(down_filt, dn);
        case (seq_phase)
            PHASE_IDLE:
            begin
                if (up_filt.level)
                begin
                    seq_phase = PHASE_RETRACT;
                    pulse_cnt = '0;
                end
                else if (down_filt.level)
                begin
                    scaled    = DWELL_WIDE_W'(dip) * DWELL_WIDE_W'(DWELL_SCALE);
                    dwell_cnt = (scaled > DWELL_MAX) ? DWELL_W'(DWELL_MAX) : scaled[DWELL_W-1:0];
                    seq_phase = PHASE_EXTEND;
                    pulse_cnt = '0;
                end
            end
            PHASE_RETRACT:
            begin
                if (pulse_finished())
                    seq_phase = PHASE_IDLE;
            end
            PHASE_EXTEND:
            begin
                if (pulse_finished())
                begin
                    step_cnt  = '0;
                    seq_phase = (dwell_cnt != '0) ? PHASE_DWELL : PHASE_RETRACT;
                end
            end
            default:
            begin
                // up cuts the dwell short
                if (up_filt.level)
                begin
                    dwell_cnt = '0;
                    step_cnt  = '0;
                    seq_phase = PHASE_RETRACT;
                    pulse_cnt = '0;
                end
                else
                begin
                    step_cnt = step_cnt + 1'b1;
                    if (step_cnt >= step_len || step_cnt == '0)
                    begin
                        step_cnt = '0;
                        if (dwell_cnt != '0)
                            dwell_cnt = dwell_cnt - 1'b1;
                        if (dwell_cnt == '0)
                        begin
                            seq_phase = PHASE_RETRACT;
                            pulse_cnt = '0;
                        end
                    end
                end
            end
        endcase
        r.up_pressed   = up_filt.level;
        r.down_pressed = down_filt.level;
        expected_drive_q.push_back(r);
    endtask

    // register write into the shadow copy, spare index ignored
    task automatic apply_register(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_BOUNCE_THRESHOLD: bounce_thr = data[THRESH_W-1:0];
            CFG_PULSE_TICKS:      pulse_len  = data[PULSE_W-1:0];
            CFG_STEP_TICKS:       step_len   = data[STEP_W-1:0];
            default:              ;
        endcase
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // transfer monitor: results checked before the same edge's tick is predicted
    always @(posedge clk)
    begin
        press_result_t got;
        press_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got = press_result_t'(m_tdata[RES_W-1:0]);
                if (expected_drive_q.size() == 0)
                begin
                    $error("result transfer with no tick pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_drive_q.pop_front();
                    check_field("extend_drive", 32'(want.extend_drive),
                                32'(got.extend_drive));
                    check_field("retract_drive", 32'(want.retract_drive),
                                32'(got.retract_drive));
                    check_field("phase", 32'(want.phase), 32'(got.phase));
                    check_field("dwell_left", 32'(want.dwell_left), 32'(got.dwell_left));
                    check_field("up_pressed", 32'(want.up_pressed), 32'(got.up_pressed));
                    check_field("down_pressed", 32'(want.down_pressed),
                                32'(got.down_pressed));
                end
            end
            if (s_tvalid && s_tready)
                advance_press_model(s_tdata[0], s_tdata[1], s_tdata[DIP_WIDTH+1:2]);
            if (cfg_valid && cfg_ready)
                apply_register(cfg_index, cfg_data);
        end
    end

    // result side ready, with random stalls and a counted hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // offer one tick with random gaps, return at the falling edge after the transfer
    task automatic send_tick(input logic up, input logic dn, input logic [7:0] dip);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {{(IN_W-DIP_WIDTH-2){1'b0}}, dip[DIP_WIDTH-1:0], dn, up};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        ticks_sent++;
    endtask

    // stop offering and wait for every pending result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        drain_results();
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly short dwells, sometimes any setting
    function automatic logic [7:0] pick_dip();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return 8'($urandom_range(3));
    endfunction

    // one switch gesture longer than the threshold: bounce at the start, then a stable hold, or noise throughout
    task automatic send_gesture(input int thr);
        int kind;
        int len;
        int noise;
        logic up;
        logic dn;
        kind  = $urandom_range(9);
        up    = (kind < 3) || (kind == 7);
        dn    = (kind >= 3) && (kind <= 7);
        len   = thr + 2 + $urandom_range(6);
        noise = $urandom_range(3);
        for (int i = 0; i < len; i++)
        begin
            if (kind == 9 || (i < noise && $urandom_range(1) == 1))
                send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), pick_dip());
            else
                send_tick(up, dn, pick_dip());
        end
    endtask

    // quiet ticks during the retract pulse that follows reset
    task automatic test_reset_state();
        repeat (3) send_tick(1'b0, 1'b0, 8'h00);
    endtask

    // spare index, masking of wide data, largest and zero lengths
    task automatic test_register_extremes();
        write_reg(CFG_SPARE_INDEX, 20'h12345);
        write_reg(CFG_BOUNCE_THRESHOLD, 20'hFFFFF);
        write_reg(CFG_PULSE_TICKS, 20'hFFFFF);
        write_reg(CFG_STEP_TICKS, 20'hFFFFF);
        repeat (3) send_tick(1'b1, 1'b1, 8'hFF);
        write_reg(CFG_BOUNCE_THRESHOLD, 20'h00000);
        write_reg(CFG_PULSE_TICKS, 20'h00000);
        write_reg(CFG_STEP_TICKS, 20'h00000);
        repeat (2) send_tick(1'b0, 1'b0, 8'h00);
    endtask

    // full press cycles with the shortest debounce and pulses
    task automatic test_press_sequences();
        write_reg(CFG_PULSE_TICKS, 20'd1);
        write_reg(CFG_STEP_TICKS, 20'd1);
        // down with the largest setting, then up aborts the dwell
        repeat (2) send_tick(1'b0, 1'b1, 8'hFF);
        repeat (3) send_tick(1'b0, 1'b0, 8'h00);
        repeat (2) send_tick(1'b1, 1'b0, 8'h00);
        // held up restarts the retract pulse on return to idle
        repeat (3) send_tick(1'b1, 1'b0, 8'h00);
        repeat (2) send_tick(1'b0, 1'b0, 8'h00);
        // zero dwell goes straight from extend to retract
        repeat (2) send_tick(1'b0, 1'b1, 8'h00);
        repeat (3) send_tick(1'b0, 1'b0, 8'h00);
        // both pressed, up wins
        repeat (2) send_tick(1'b1, 1'b1, 8'h5A);
        repeat (2) send_tick(1'b0, 1'b0, 8'hA5);
    endtask

    // random gestures under one setting until the tick budget is used
    task automatic test_random_traffic(input int thr, input int pulse, input int step,
                                       input int n_ticks);
        int stop_at;
        write_reg(CFG_BOUNCE_THRESHOLD, CFG_W'(thr));
        write_reg(CFG_PULSE_TICKS, CFG_W'(pulse));
        write_reg(CFG_STEP_TICKS, CFG_W'(step));
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
            send_gesture(thr);
    endtask

    // long receiver hold-off while ticks keep coming, then a full pause
    task automatic test_output_stall();
        int stop_at;
        write_reg(CFG_BOUNCE_THRESHOLD, 20'd1);
        write_reg(CFG_PULSE_TICKS, 20'd3);
        hold_left = 80;
        stop_at = ticks_sent + 40;
        while (ticks_sent < stop_at)
            send_gesture(1);
        drain_results();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_register_extremes();
        test_press_sequences();

        send_idle_pct = 10;
        recv_idle_pct = 71;
        test_random_traffic(3, 2, 1, 200);
        test_output_stall();

        send_idle_pct = 71;
        recv_idle_pct = 10;
        test_random_traffic(0, 1, 3, 200);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(6, 5, 2, 200);

        // wind down
        drain_results();
        repeat (4) @(posedge clk);
        if (expected_drive_q.size() != 0)
        begin
            $error("%0d results never arrived", expected_drive_q.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
